>>> hdl/text_console_char_writer_core_macros.svh
// Assertion macros shared by the console writer RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define TCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`else

`define TCW_ASSERT_SAME(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/tcw_pkg.sv
package tcw_pkg;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Cell value after reset: space, colour 7
    localparam logic [7:0]  RST_COLOR = 8'h07;
    localparam logic [15:0] RST_CELL  = {RST_COLOR, CH_SPACE};

    // Configuration register indexes
    localparam logic REG_TEXT_COLOR  = 1'b0;
    localparam logic REG_CURSOR_HIDE = 1'b1;

    // Stream payload widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int HW_OFF_W    = 11;

    typedef logic [5:0] step_t;

    typedef enum logic [1:0] {
        M_NONE,
        M_READ,
        M_READ_AHEAD,
        M_WRITE
    } mem_op_t;

    typedef enum logic [2:0] {
        W_RST,
        W_SPACE,
        W_CHAR,
        W_RECOLOR,
        W_COPY
    } wsel_t;

    typedef enum logic [1:0] {
        A_HOLD,
        A_ZERO,
        A_CUR,
        A_INC
    } addr_op_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_NEXTROW,
        C_ROWDEC,
        C_START,
        C_COLINC,
        C_COLDEC,
        C_PREVEND
    } cur_op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_IS_NL,
        COND_IS_CR,
        COND_IS_BS,
        COND_ROW_NOT_LAST,
        COND_COL_NOT_LAST,
        COND_COL_ZERO,
        COND_ROW_ZERO,
        COND_START_OFF,
        COND_ADDR_NOT_LAST,
        COND_ADDR_NOT_COPY_END,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic     take;
        logic     emit;
        logic     hw_upd;
        logic     set_scroll;
        mem_op_t  mem_op;
        wsel_t    wsel;
        addr_op_t addr_op;
        cur_op_t  cur_op;
        cond_t    cond;
        step_t    target;
    } ctl_word_t;

    // Program steps
    localparam step_t ST_CLR    = 6'd0;
    localparam step_t ST_IDLE   = 6'd1;
    localparam step_t ST_DISP   = 6'd2;
    localparam step_t ST_DISP1  = 6'd3;
    localparam step_t ST_DISP2  = 6'd4;
    localparam step_t ST_DR0    = 6'd5;
    localparam step_t ST_DR1    = 6'd6;
    localparam step_t ST_DR2    = 6'd7;
    localparam step_t ST_DR3    = 6'd8;
    localparam step_t ST_DRW    = 6'd9;
    localparam step_t ST_DRW1   = 6'd10;
    localparam step_t ST_DRS    = 6'd11;
    localparam step_t ST_DRS1   = 6'd12;
    localparam step_t ST_RC     = 6'd13;
    localparam step_t ST_RC1    = 6'd14;
    localparam step_t ST_NL     = 6'd15;
    localparam step_t ST_SCR    = 6'd16;
    localparam step_t ST_SCR1   = 6'd17;
    localparam step_t ST_SCR2   = 6'd18;
    localparam step_t ST_SCR3   = 6'd19;
    localparam step_t ST_SCR4   = 6'd20;
    localparam step_t ST_SCR5   = 6'd21;
    localparam step_t ST_NLM    = 6'd22;
    localparam step_t ST_NLM1   = 6'd23;
    localparam step_t ST_NLM2   = 6'd24;
    localparam step_t ST_CR     = 6'd25;
    localparam step_t ST_CR1    = 6'd26;
    localparam step_t ST_CR2    = 6'd27;
    localparam step_t ST_BS     = 6'd28;
    localparam step_t ST_BS1    = 6'd29;
    localparam step_t ST_BS2    = 6'd30;
    localparam step_t ST_BS3    = 6'd31;
    localparam step_t ST_BSU    = 6'd32;
    localparam step_t ST_BSU1   = 6'd33;
    localparam step_t ST_EMIT   = 6'd34;
    localparam step_t ST_EMIT1  = 6'd35;

    localparam ctl_word_t CTL_NOP = '{
        take: 1'b0, emit: 1'b0, hw_upd: 1'b0, set_scroll: 1'b0,
        mem_op: M_NONE, wsel: W_RST, addr_op: A_HOLD, cur_op: C_HOLD,
        cond: COND_NEVER, target: ST_IDLE
    };

    // Control store
    function automatic ctl_word_t ucode(input step_t pc);
        ctl_word_t w;
        w = CTL_NOP;
        unique case (pc)
            // Sweep the screen to blanks after reset
            ST_CLR:
            begin
                w.mem_op  = M_WRITE;
                w.wsel    = W_RST;
                w.addr_op = A_INC;
                w.cond    = COND_ADDR_NOT_LAST;
                w.target  = ST_CLR;
            end
            ST_IDLE:
            begin
                w.take   = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = ST_IDLE;
            end
            ST_DISP:
            begin
                w.cond   = COND_IS_NL;
                w.target = ST_NL;
            end
            ST_DISP1:
            begin
                w.cond   = COND_IS_CR;
                w.target = ST_CR;
            end
            ST_DISP2:
            begin
                w.cond   = COND_IS_BS;
                w.target = ST_BS;
            end
            // Any other byte is drawn at the cursor
            ST_DR0:
            begin
                w.addr_op = A_CUR;
            end
            ST_DR1:
            begin
                w.mem_op = M_WRITE;
                w.wsel   = W_CHAR;
                w.cond   = COND_COL_NOT_LAST;
                w.target = ST_DRS;
            end
            ST_DR2:
            begin
                w.cond   = COND_ROW_NOT_LAST;
                w.target = ST_DRW;
            end
            ST_DR3:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_SCR;
            end
            ST_DRW:
            begin
                w.cur_op = C_NEXTROW;
            end
            ST_DRW1:
            begin
                w.addr_op = A_CUR;
                w.hw_upd  = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = ST_RC;
            end
            ST_DRS:
            begin
                w.cur_op = C_COLINC;
            end
            ST_DRS1:
            begin
                w.addr_op = A_CUR;
                w.hw_upd  = 1'b1;
            end
            // Give the new cursor cell the current colour
            ST_RC:
            begin
                w.mem_op = M_READ;
            end
            ST_RC1:
            begin
                w.mem_op = M_WRITE;
                w.wsel   = W_RECOLOR;
                w.cond   = COND_ALWAYS;
                w.target = ST_EMIT;
            end
            // Newline
            ST_NL:
            begin
                w.cond   = COND_ROW_NOT_LAST;
                w.target = ST_NLM;
            end
            // Scroll up one row
            ST_SCR:
            begin
                w.addr_op    = A_ZERO;
                w.set_scroll = 1'b1;
            end
            ST_SCR1:
            begin
                w.mem_op = M_READ_AHEAD;
            end
            ST_SCR2:
            begin
                w.mem_op  = M_WRITE;
                w.wsel    = W_COPY;
                w.addr_op = A_INC;
                w.cond    = COND_ADDR_NOT_COPY_END;
                w.target  = ST_SCR1;
            end
            ST_SCR3:
            begin
                w.mem_op  = M_WRITE;
                w.wsel    = W_SPACE;
                w.addr_op = A_INC;
                w.cond    = COND_ADDR_NOT_LAST;
                w.target  = ST_SCR3;
            end
            ST_SCR4:
            begin
                w.cur_op = C_ROWDEC;
                w.cond   = COND_IS_NL;
                w.target = ST_NLM;
            end
            ST_SCR5:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_DRW;
            end
            ST_NLM:
            begin
                w.cur_op = C_NEXTROW;
            end
            ST_NLM1:
            begin
                w.addr_op = A_CUR;
                w.hw_upd  = 1'b1;
            end
            ST_NLM2:
            begin
                w.mem_op = M_WRITE;
                w.wsel   = W_SPACE;
                w.cond   = COND_ALWAYS;
                w.target = ST_EMIT;
            end
            // Carriage return
            ST_CR:
            begin
                w.cond   = COND_START_OFF;
                w.target = ST_EMIT;
            end
            ST_CR1:
            begin
                w.cur_op = C_START;
            end
            ST_CR2:
            begin
                w.hw_upd = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = ST_EMIT;
            end
            // Backspace
            ST_BS:
            begin
                w.cond   = COND_COL_ZERO;
                w.target = ST_BSU;
            end
            ST_BS1:
            begin
                w.cur_op = C_COLDEC;
            end
            ST_BS2:
            begin
                w.addr_op = A_CUR;
                w.hw_upd  = 1'b1;
            end
            ST_BS3:
            begin
                w.mem_op = M_WRITE;
                w.wsel   = W_SPACE;
                w.cond   = COND_ALWAYS;
                w.target = ST_EMIT;
            end
            ST_BSU:
            begin
                w.cond   = COND_ROW_ZERO;
                w.target = ST_EMIT;
            end
            ST_BSU1:
            begin
                w.cur_op = C_PREVEND;
                w.cond   = COND_ALWAYS;
                w.target = ST_BS2;
            end
            // Hand the result to the output register
            ST_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = ST_IDLE;
            end
            ST_EMIT1:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_EMIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/text_console_char_writer_core.sv
// Text console character writer. Each input item is one byte plus a prompt
// start position; each item yields exactly one result item with the echoed
// byte, the new cursor, the start row after any scroll, the hardware cursor
// offset and a scroll flag. The screen store (ROWS x COLS cells of 16 bits)
// is a single-port memory driven by a small microprogram. After reset the
// block sweeps every cell of the store to blanks before it takes its first
// item; configuration writes are taken meanwhile. The block takes no new
// item until its sequencer has handed the last one to the output register
// and is back in its idle step. Of the bytes that do not scroll, an offscreen
// carriage return passes the fewest steps and a drawn byte that wraps to the
// next row the most. A byte that scrolls also copies each cell of the upper
// rows from the cell below it, a read and then a write through the one
// memory port, and then blanks the bottom row.
// The block accepts a new item while the previous result waits in the
// output register; a further result holds the sequencer in its emit step
// and the input stalls until the output register frees up.
`include "text_console_char_writer_core_macros.svh"

module text_console_char_writer_core #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] char_in, [12:8] prompt_row, [19:13] prompt_col, [23:20] zero
    input  logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] char_echo, [12:8] row_out, [19:13] col_out,
    // [25:20] prompt_row_out, [36:26] hw_cursor_offset, [37] scrolled,
    // [39:38] zero
    output logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int LW     = $clog2(NCELLS + 1);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int LWX    = LW + tcw_pkg::HW_OFF_W;
    localparam int RWX    = RW + 5;
    localparam int CWX    = CW + 7;

    localparam logic [AW-1:0] ADDR_LAST     = AW'(NCELLS - 1);
    localparam logic [AW-1:0] ADDR_COPY_END = AW'(NCELLS - COLS - 1);
    localparam logic [AW-1:0] ROW_STRIDE    = AW'(COLS);
    localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST      = CW'(COLS - 1);
    localparam logic [LWX-1:0] HIDDEN_WIDE  = LWX'(NCELLS);
    localparam logic [tcw_pkg::HW_OFF_W-1:0] HIDDEN_OFF =
        HIDDEN_WIDE[tcw_pkg::HW_OFF_W-1:0];

    // Control and datapath registers
    tcw_pkg::step_t     pc_reg, pc_next;
    tcw_pkg::ctl_word_t ctl;
    logic               cond_hit;

    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [tcw_pkg::HW_OFF_W-1:0] hw_reg, hw_next;
    logic [7:0]         color_reg;
    logic               hide_reg;
    logic               scroll_reg;

    logic [7:0]         ch_reg;
    logic [4:0]         srow_reg;
    logic [6:0]         scol_reg;

    logic [15:0]        screen_mem [NCELLS];
    logic [15:0]        rdata_reg;
    logic [AW-1:0]      mem_addr;
    logic [15:0]        wdata;
    logic               mem_we;
    logic               mem_re;

    logic [LW-1:0]      cur_lin;
    logic [LWX-1:0]     cur_lin_wide;
    logic [RWX-1:0]     row_wide;
    logic [CWX-1:0]     col_wide;
    logic               start_off;
    logic               take;
    logic               out_free;
    logic               do_emit;
    logic               cfg_we;

    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic [4:0]         out_row_reg;
    logic [6:0]         out_col_reg;
    logic [5:0]         out_srow_reg;
    logic [tcw_pkg::HW_OFF_W-1:0] out_hw_reg;
    logic               out_scr_reg;

    // Decode the current step
    assign ctl = tcw_pkg::ucode(pc_reg);

    assign take     = ctl.take & s_axis_tvalid;
    assign out_free = ~out_valid_reg | m_axis_tready;
    assign do_emit  = ctl.emit & out_free;
    assign cfg_we   = cfg_valid & cfg_ready;

    assign s_axis_tready = ctl.take;
    assign cfg_ready     = 1'b1;

    // Linear cell index of the cursor
    assign cur_lin      = LW'(row_reg) * LW'(COLS) + LW'(col_reg);
    assign cur_lin_wide = LWX'(cur_lin);
    assign row_wide     = RWX'(row_reg);
    assign col_wide     = CWX'(col_reg);

    assign start_off = ({2'b00, srow_reg} >= 7'(ROWS)) || ({1'b0, scol_reg} >= 8'(COLS));

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctl.cond)
            tcw_pkg::COND_NEVER:             cond_hit = 1'b0;
            tcw_pkg::COND_ALWAYS:            cond_hit = 1'b1;
            tcw_pkg::COND_NO_INPUT:          cond_hit = ~s_axis_tvalid;
            tcw_pkg::COND_IS_NL:             cond_hit = (ch_reg == tcw_pkg::CH_NL);
            tcw_pkg::COND_IS_CR:             cond_hit = (ch_reg == tcw_pkg::CH_CR);
            tcw_pkg::COND_IS_BS:             cond_hit = (ch_reg == tcw_pkg::CH_BS);
            tcw_pkg::COND_ROW_NOT_LAST:      cond_hit = (row_reg != ROW_LAST);
            tcw_pkg::COND_COL_NOT_LAST:      cond_hit = (col_reg != COL_LAST);
            tcw_pkg::COND_COL_ZERO:          cond_hit = (col_reg == '0);
            tcw_pkg::COND_ROW_ZERO:          cond_hit = (row_reg == '0);
            tcw_pkg::COND_START_OFF:         cond_hit = start_off;
            tcw_pkg::COND_ADDR_NOT_LAST:     cond_hit = (addr_reg != ADDR_LAST);
            tcw_pkg::COND_ADDR_NOT_COPY_END: cond_hit = (addr_reg != ADDR_COPY_END);
            tcw_pkg::COND_OUT_FREE:          cond_hit = out_free;
            default:                         cond_hit = 1'b0;
        endcase
    end

    assign pc_next = cond_hit ? ctl.target : pc_reg + 6'd1;

    // Cursor moves
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        unique case (ctl.cur_op)
            tcw_pkg::C_HOLD:
            begin
                row_next = row_reg;
            end
            tcw_pkg::C_NEXTROW:
            begin
                row_next = row_reg + 1'b1;
                col_next = '0;
            end
            tcw_pkg::C_ROWDEC:
            begin
                row_next = row_reg - 1'b1;
            end
            tcw_pkg::C_START:
            begin
                row_next = RW'(srow_reg);
                col_next = CW'(scol_reg);
            end
            tcw_pkg::C_COLINC:
            begin
                col_next = col_reg + 1'b1;
            end
            tcw_pkg::C_COLDEC:
            begin
                col_next = col_reg - 1'b1;
            end
            tcw_pkg::C_PREVEND:
            begin
                row_next = row_reg - 1'b1;
                col_next = COL_LAST;
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // Store address
    always_comb
    begin
        unique case (ctl.addr_op)
            tcw_pkg::A_HOLD: addr_next = addr_reg;
            tcw_pkg::A_ZERO: addr_next = '0;
            tcw_pkg::A_CUR:  addr_next = AW'(cur_lin);
            tcw_pkg::A_INC:  addr_next = addr_reg + 1'b1;
            default:         addr_next = addr_reg;
        endcase
    end

    // Hardware cursor: config wins, else follow the cursor while visible
    always_comb
    begin
        hw_next = hw_reg;
        if (cfg_we && (cfg_index == tcw_pkg::REG_CURSOR_HIDE))
        begin
            hw_next = cfg_data[0] ? HIDDEN_OFF : cur_lin_wide[tcw_pkg::HW_OFF_W-1:0];
        end
        else if (ctl.hw_upd && !hide_reg)
        begin
            hw_next = cur_lin_wide[tcw_pkg::HW_OFF_W-1:0];
        end
    end

    // Write data select
    always_comb
    begin
        unique case (ctl.wsel)
            tcw_pkg::W_RST:     wdata = tcw_pkg::RST_CELL;
            tcw_pkg::W_SPACE:   wdata = {color_reg, tcw_pkg::CH_SPACE};
            tcw_pkg::W_CHAR:    wdata = {color_reg, ch_reg};
            tcw_pkg::W_RECOLOR: wdata = {color_reg, rdata_reg[7:0]};
            tcw_pkg::W_COPY:    wdata = rdata_reg;
            default:            wdata = tcw_pkg::RST_CELL;
        endcase
    end

    assign mem_we   = (ctl.mem_op == tcw_pkg::M_WRITE);
    assign mem_re   = (ctl.mem_op == tcw_pkg::M_READ) || (ctl.mem_op == tcw_pkg::M_READ_AHEAD);
    assign mem_addr = (ctl.mem_op == tcw_pkg::M_READ_AHEAD) ? addr_reg + ROW_STRIDE : addr_reg;

    // Screen store, one port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_addr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_addr];
        end
    end

    // Sequencer and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= tcw_pkg::ST_CLR;
            row_reg    <= '0;
            col_reg    <= '0;
            addr_reg   <= '0;
            hw_reg     <= '0;
            color_reg  <= tcw_pkg::RST_COLOR;
            hide_reg   <= 1'b0;
            scroll_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            addr_reg <= addr_next;
            hw_reg   <= hw_next;
            if (cfg_we && (cfg_index == tcw_pkg::REG_TEXT_COLOR))
            begin
                color_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == tcw_pkg::REG_CURSOR_HIDE))
            begin
                hide_reg <= cfg_data[0];
            end
            if (take)
            begin
                scroll_reg <= 1'b0;
            end
            else if (ctl.set_scroll)
            begin
                scroll_reg <= 1'b1;
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg   <= s_axis_tdata[7:0];
            srow_reg <= s_axis_tdata[12:8];
            scol_reg <= s_axis_tdata[19:13];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            out_char_reg <= ch_reg;
            out_row_reg  <= row_wide[4:0];
            out_col_reg  <= col_wide[6:0];
            out_srow_reg <= {1'b0, srow_reg} - {5'd0, scroll_reg};
            out_hw_reg   <= hw_reg;
            out_scr_reg  <= scroll_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_scr_reg, out_hw_reg, out_srow_reg,
                            out_col_reg, out_row_reg, out_char_reg};

    // Checks
    `TCW_ASSERT_SAME(a_cursor_in_range, 1'b1, (row_reg <= ROW_LAST) && (col_reg <= COL_LAST))
    `TCW_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TCW_ASSERT_SAME(a_scroll_leaves_last_row, (pc_reg == tcw_pkg::ST_EMIT) && scroll_reg,
                     row_reg == ROW_LAST)
    `TCW_ASSERT_SAME(a_hidden_cursor_parked, hide_reg, hw_reg == HIDDEN_OFF)

endmodule

>>> sim/text_console_char_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_char_writer_core_tb;

    localparam int ROWS         = 25;
    localparam int COLS         = 80;
    localparam int CELLS        = ROWS * COLS;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 120;

    // One result item as it sits in m_axis_tdata[37:0]
    typedef struct packed {
        logic              scrolled;
        logic [10:0]       hw_off;
        logic signed [5:0] prompt_row;
        logic [6:0]        col;
        logic [4:0]        row;
        logic [7:0]        ch;
    } console_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [tcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_index;
    logic [7:0]                      cfg_data;

    // Predicted console state
    int pred_row;
    int pred_col;
    int hw_cursor;
    bit pred_hidden;

    console_result_t pending_results[$];
    int  mismatch_count;
    int  cycle_count;
    bit  gaps_on;
    int  hold_requests;
    int  holds_done;

    text_console_char_writer_core #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Count cycles for the watchdog
    initial cycle_count = 0;
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly no gap, some short, a few long
    function automatic int next_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Move the logical cursor; the hardware cursor follows while visible
    function automatic void place_cursor(int row, int col);
        if (row < 0 || row >= ROWS || col < 0 || col >= COLS)
            return;
        pred_row = row;
        pred_col = col;
        if (!pred_hidden)
            hw_cursor = row * COLS + col;
    endfunction

    // Advance the console state by one byte and build its result item
    function automatic console_result_t predict_console_step(
        input logic [7:0] ch,
        input logic [4:0] srow,
        input logic [6:0] scol
    );
        console_result_t r;
        logic            did_scroll;
        did_scroll = 1'b0;
        if (ch == tcw_pkg::CH_NL)
        begin
            if (pred_row + 1 >= ROWS)
            begin
                place_cursor(pred_row - 1, pred_col);
                did_scroll = 1'b1;
            end
            place_cursor(pred_row + 1, 0);
        end
        else if (ch == tcw_pkg::CH_CR)
        begin
            // Offscreen start position leaves the cursor alone
            place_cursor(int'(srow), int'(scol));
        end
        else if (ch == tcw_pkg::CH_BS)
        begin
            if (pred_col > 0)
                place_cursor(pred_row, pred_col - 1);
            else if (pred_row > 0)
                place_cursor(pred_row - 1, COLS - 1);
        end
        else
        begin
            if (pred_col + 1 >= COLS)
            begin
                if (pred_row + 1 >= ROWS)
                begin
                    place_cursor(pred_row - 1, pred_col);
                    did_scroll = 1'b1;
                end
                place_cursor(pred_row + 1, 0);
            end
            else
                place_cursor(pred_row, pred_col + 1);
        end
        r.ch         = ch;
        r.row        = pred_row[4:0];
        r.col        = pred_col[6:0];
        r.prompt_row = did_scroll ? 6'({1'b0, srow}) - 6'd1 : 6'({1'b0, srow});
        r.hw_off     = hw_cursor[10:0];
        r.scrolled   = did_scroll;
        return r;
    endfunction

    // Send one item; entered and left at a falling edge
    task automatic send_char(input logic [7:0] ch, input logic [4:0] srow,
                             input logic [6:0] scol);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, scol, srow, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_console_step(ch, srow, scol));
        @(negedge clk);
    endtask

    // Write one register; the predictor tracks the cursor hide bit
    task automatic write_register(input logic index, input logic [7:0] data);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b1;
        cfg_index     <= index;
        cfg_data      <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == tcw_pkg::REG_CURSOR_HIDE)
        begin
            pred_hidden = data[0];
            hw_cursor   = pred_hidden ? CELLS : pred_row * COLS + pred_col;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: random stalls, and a long hold when the test asks for one
    initial
    begin
        int stall_left;
        int r;
        stall_left    = 0;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                m_axis_tready <= 1'b1;
                if (gaps_on && r >= 65)
                    stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin
        console_result_t got;
        console_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = console_result_t'(m_axis_tdata[37:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("char_echo", want.ch, got.ch);
                check_field("row_out", want.row, got.row);
                check_field("col_out", want.col, got.col);
                check_field("prompt_row_out", int'(want.prompt_row), int'(got.prompt_row));
                check_field("hw_cursor_offset", want.hw_off, got.hw_off);
                check_field("scrolled", want.scrolled, got.scrolled);
            end
        end
    end

    // Both registers at their extremes while the screen sweep runs
    task automatic test_register_extremes();
        write_register(tcw_pkg::REG_TEXT_COLOR, 8'hFF);
        write_register(tcw_pkg::REG_CURSOR_HIDE, 8'd0);
    endtask

    // Edges of the cursor, start position and byte codes
    task automatic test_cursor_edges();
        send_char(8'h41, 5'd0, 7'd0);
        send_char(tcw_pkg::CH_BS, 5'd0, 7'd0);
        // backspace at top left changes nothing
        send_char(tcw_pkg::CH_BS, 5'd0, 7'd0);
        send_char(tcw_pkg::CH_CR, 5'd0, 7'd79);
        // drawn at the last column wraps to the next row
        send_char(8'hFF, 5'd0, 7'd0);
        send_char(tcw_pkg::CH_BS, 5'd0, 7'd0);
        send_char(tcw_pkg::CH_NL, 5'd0, 7'd0);
        send_char(tcw_pkg::CH_CR, 5'd24, 7'd79);
        // draw at bottom right scrolls
        send_char(8'h00, 5'd24, 7'd0);
        // newline at the bottom with start row 0 scrolls it off the top
        send_char(tcw_pkg::CH_NL, 5'd0, 7'd0);
        // offscreen start positions leave the cursor alone
        send_char(tcw_pkg::CH_CR, 5'd31, 7'd127);
        send_char(tcw_pkg::CH_CR, 5'd24, 7'd80);
        send_char(tcw_pkg::CH_CR, 5'd25, 7'd0);
        send_char(8'h7F, 5'd31, 7'd127);
        send_char(8'h80, 5'd0, 7'd0);
        send_char(tcw_pkg::CH_CR, 5'd0, 7'd0);
        drain_results();
    endtask

    // Hidden hardware cursor stays parked, then snaps back to the cursor
    task automatic test_hidden_cursor();
        write_register(tcw_pkg::REG_CURSOR_HIDE, 8'd1);
        write_register(tcw_pkg::REG_TEXT_COLOR, 8'h00);
        send_char(tcw_pkg::CH_NL, 5'd3, 7'd0);
        send_char(tcw_pkg::CH_CR, 5'd24, 7'd79);
        send_char(tcw_pkg::CH_SPACE, 5'd24, 7'd79);
        send_char(tcw_pkg::CH_BS, 5'd0, 7'd0);
        drain_results();
        write_register(tcw_pkg::REG_CURSOR_HIDE, 8'd0);
        send_char(8'h7A, 5'd0, 7'd0);
        drain_results();
    endtask

    // Hold off the result side so the block fills up and stalls its input
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_requests++;
        send_char(tcw_pkg::CH_CR, 5'd5, 7'd10);
        repeat (7) send_char(8'($urandom_range(32, 126)), 5'd0, 7'd0);
        drain_results();
        gaps_on = 1'b1;
    endtask

    function automatic logic [4:0] pick_prompt_row();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 5'd0;
        if (r < 5)
            return 5'(ROWS - 1);
        if (r < 6)
            return 5'(ROWS - 2);
        if (r < 7)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [6:0] pick_prompt_col();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 7'd0;
        if (r < 5)
            return 7'(COLS - 1);
        if (r < 6)
            return 7'(COLS - 2);
        if (r < 7)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, COLS - 1));
    endfunction

    // Random bytes in phases, registers changed between phases
    task automatic test_random_stream();
        int         r;
        logic [7:0] ch;
        for (int phase = 0; phase < 3; phase++)
        begin
            write_register(tcw_pkg::REG_TEXT_COLOR, 8'($urandom_range(0, 255)));
            write_register(tcw_pkg::REG_CURSOR_HIDE, 8'(phase == 1));
            gaps_on = (phase != 2);
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    ch = 8'($urandom_range(0, 255));
                else if (r < 55)
                    ch = tcw_pkg::CH_NL;
                else if (r < 70)
                    ch = tcw_pkg::CH_BS;
                else
                    ch = tcw_pkg::CH_CR;
                if (ch == tcw_pkg::CH_CR)
                    send_char(ch, pick_prompt_row(), pick_prompt_col());
                else
                    send_char(ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = tcw_pkg::REG_TEXT_COLOR;
        cfg_data       = 8'h00;
        pred_row       = 0;
        pred_col       = 0;
        hw_cursor      = 0;
        pred_hidden    = 1'b0;
        mismatch_count = 0;
        hold_requests  = 0;
        gaps_on        = 1'b1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_register_extremes();
        test_cursor_edges();
        test_hidden_cursor();
        test_output_backpressure();
        test_random_stream();

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/text_console_char_writer_core.sv
sim/text_console_char_writer_core_tb.sv
